/* rtl/psrs_pkg.sv */
// ----------------------------------------------------------------------------
// psrs_pkg
// Types, constants and small helper functions shared by the paired-sample
// regression statistics block, its divider and its square root unit.
// ----------------------------------------------------------------------------
`default_nettype none

package psrs_pkg;

    // Width of one signed sample in the input transfer.
    localparam int SAMPLE_BITS = 16;

    // Fraction bit counts used by the divider.
    localparam logic [4:0] SH_INT = 5'd0;
    localparam logic [4:0] SH_Q16 = 5'd16;
    localparam logic [4:0] SH_Q30 = 5'd30;

    // Integer quotient bits that the divider always produces.
    localparam logic [7:0] DIV_BASE_STEPS = 8'd128;

    // Saturation limits, as magnitudes.
    localparam logic [63:0] LIM_MEAN  = 64'h0000_0000_8000_0000;
    localparam logic [63:0] LIM_CORR  = 64'h0000_0000_4000_0000;
    localparam logic [63:0] LIM_FIT   = 64'h0000_8000_0000_0000;
    localparam logic [63:0] MAX_UQ48  = 64'h0000_FFFF_FFFF_FFFF;

    // Start value of the square root's one-hot trial bit.
    localparam logic [63:0] SQRT_START_BIT = 64'h4000_0000_0000_0000;

    // Input action codes.
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef struct packed {
        logic                          action;
        logic signed [SAMPLE_BITS-1:0] x_sample;
        logic signed [SAMPLE_BITS-1:0] y_sample;
    } t_in_item;

    typedef struct packed {
        logic        [15:0] sample_count;
        logic signed [31:0] mean_x;
        logic signed [31:0] mean_y;
        logic        [47:0] mean_sq_error;
        logic        [47:0] centered_sq_error;
        logic signed [31:0] correlation;
        logic signed [47:0] slope;
        logic signed [47:0] intercept;
        logic        [47:0] residual_variance;
        logic               fit_degenerate;
        logic               no_samples;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_XX,
        S_YY,
        S_XY,
        S_CHK,
        S_NSXX,
        S_SXSX,
        S_NSYY,
        S_SYSY,
        S_NSXY,
        S_SXSY,
        S_NN,
        S_MX,
        S_MY,
        S_MSE,
        S_CSE,
        S_RTX,
        S_RTY,
        S_DEN,
        S_COR,
        S_VARX,
        S_RESD,
        S_SLOPE,
        S_P1,
        S_P2,
        S_ICPT,
        S_PQ1,
        S_PQ2,
        S_RES1,
        S_RES2,
        S_OUT
    } t_seq_state;

    // Magnitude of a two's-complement 64-bit value.
    function automatic logic [63:0] f_mag(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // Negative values become zero.
    function automatic logic [63:0] f_clamp0(input logic [63:0] v);
        return v[63] ? 64'd0 : v;
    endfunction

    // Unsigned saturation of a 128-bit quotient to a 64-bit limit.
    function automatic logic [63:0] f_usat(input logic [127:0] q, input logic [63:0] lim);
        return ((q[127:64] != 64'd0) || (q[63:0] > lim)) ? lim : q[63:0];
    endfunction

    // Signed saturation of a quotient of magnitudes to [-lim, lim-1].
    function automatic logic [63:0] f_ssat(input logic [127:0] q, input logic [63:0] lim,
                                           input logic neg);
        logic [63:0] m;
        m = f_usat(q, neg ? lim : (lim - 64'd1));
        return neg ? (64'd0 - m) : m;
    endfunction

endpackage

`default_nettype wire

/* rtl/psrs_mul.sv */
// ----------------------------------------------------------------------------
// psrs_mul
// Shared 64 x 64 -> 128 unsigned multiplier built from one 32 x 32 multiplier
// that is used four times; the partial products are accumulated one a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module psrs_mul (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [63:0]  i_a,
    input  wire logic [63:0]  i_b,
    output logic              o_done,
    output logic [127:0]      o_prod
);

    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [127:0] r_acc;
    logic [63:0]  r_pp;
    logic [1:0]   r_pp_sh;
    logic         r_pp_v;
    logic [2:0]   r_k;
    logic         r_busy;

    logic [31:0]  op_a;
    logic [31:0]  op_b;
    logic [1:0]   op_sh;
    logic [127:0] pp_shifted;

    always_comb begin
        case (r_k[1:0])
            2'd0: begin
                op_a = r_a[31:0];  op_b = r_b[31:0];  op_sh = 2'd0;
            end
            2'd1: begin
                op_a = r_a[31:0];  op_b = r_b[63:32]; op_sh = 2'd1;
            end
            2'd2: begin
                op_a = r_a[63:32]; op_b = r_b[31:0];  op_sh = 2'd1;
            end
            default: begin
                op_a = r_a[63:32]; op_b = r_b[63:32]; op_sh = 2'd2;
            end
        endcase
    end

    always_comb begin
        case (r_pp_sh)
            2'd0:    pp_shifted = {64'd0, r_pp};
            2'd1:    pp_shifted = {32'd0, r_pp, 32'd0};
            default: pp_shifted = {r_pp, 64'd0};
        endcase
    end

    assign o_done = r_busy && (r_k == 3'd4) && !r_pp_v;
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= 3'd0;
            r_pp_v <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_k    <= 3'd0;
            r_pp_v <= 1'b0;
            r_a    <= i_a;
            r_b    <= i_b;
            r_acc  <= 128'd0;
        end else if (r_busy) begin
            if (r_k != 3'd4) begin
                r_pp    <= 64'(op_a) * 64'(op_b);
                r_pp_sh <= op_sh;
                r_pp_v  <= 1'b1;
                r_k     <= r_k + 3'd1;
            end else begin
                r_pp_v <= 1'b0;
            end
            if (r_pp_v) begin
                r_acc <= r_acc + pp_shifted;
            end
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/psrs_div.sv */
// ----------------------------------------------------------------------------
// psrs_div
// Shared restoring divider: floor(num * 2^sh / den) with a 128-bit numerator
// and 64-bit divisor, one quotient bit per cycle. A quotient that does not
// fit in 128 bits reads as all ones; a zero divisor gives zero.
// ----------------------------------------------------------------------------
`default_nettype none

module psrs_div (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [127:0] i_num,
    input  wire logic [4:0]   i_sh,
    input  wire logic [63:0]  i_den,
    output logic              o_done,
    output logic [127:0]      o_quo
);

    import psrs_pkg::*;

    logic [159:0] r_num;
    logic [63:0]  r_rem;
    logic [127:0] r_quo;
    logic [63:0]  r_den;
    logic [7:0]   r_cnt;
    logic         r_big;
    logic         r_zero;
    logic         r_busy;

    logic [64:0]  trial;
    logic         ge;
    logic [63:0]  rem_next;

    // The 64-bit remainder can carry out one bit before the compare.
    assign trial    = {r_rem, r_num[159]};
    assign ge       = trial[64] || (trial[63:0] >= r_den);
    assign rem_next = ge ? (trial[63:0] - r_den) : trial[63:0];

    assign o_done = r_busy && (r_cnt == 8'd0);
    assign o_quo  = r_zero ? 128'd0 : (r_big ? {128{1'b1}} : r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 8'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_num  <= {i_num, 32'd0};
            r_rem  <= 64'd0;
            r_quo  <= 128'd0;
            r_den  <= i_den;
            r_big  <= 1'b0;
            r_zero <= (i_den == 64'd0);
            r_cnt  <= DIV_BASE_STEPS + {3'd0, i_sh};
        end else if (r_busy) begin
            if (r_cnt != 8'd0) begin
                r_num <= {r_num[158:0], 1'b0};
                r_rem <= rem_next;
                r_quo <= {r_quo[126:0], ge};
                // A set bit leaving the top means the quotient overflowed.
                r_big <= r_big | r_quo[127];
                r_cnt <= r_cnt - 8'd1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/psrs_sqrt.sv */
// ----------------------------------------------------------------------------
// psrs_sqrt
// Floor square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module psrs_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_val,
    output logic             o_done,
    output logic [31:0]      o_root
);

    import psrs_pkg::*;

    logic [63:0] r_v;
    logic [63:0] r_res;
    logic [63:0] r_b;
    logic        r_busy;

    logic [63:0] trial;
    logic        ge;

    assign trial  = r_res + r_b;
    assign ge     = (r_v >= trial);
    assign o_done = r_busy && (r_b == 64'd0);
    assign o_root = r_res[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_b    <= 64'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_v    <= i_val;
            r_res  <= 64'd0;
            r_b    <= SQRT_START_BIT;
        end else if (r_busy) begin
            if (r_b != 64'd0) begin
                if (ge) begin
                    r_v   <= r_v - trial;
                    r_res <= (r_res >> 1) + r_b;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_b <= r_b >> 2;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/paired_sample_regression_stats.sv */
// ----------------------------------------------------------------------------
// paired_sample_regression_stats
// Running least-squares statistics over signed (x, y) pairs.
//
// The input channel (i_in_valid / o_in_ready / i_in_data) carries either a
// pair to add or a clear command. Every accepted transfer produces exactly
// one result transfer on o_out_valid / i_out_ready / o_out_data with the
// count, means, squared errors, correlation, slope, intercept and residual.
// The configuration channel writes min_variance and is always ready; write
// it only while the block is idle.
//
// One item is handled at a time. A clear or an empty set goes straight to
// the output. An added pair runs through the sum updates and then either a
// degenerate or a full fit; the correlation division is skipped when its
// denominator is zero, and a full count that ignores the pair skips the sum
// updates. The result becomes valid in the same cycle in which the next
// transfer can be taken. The arithmetic runs on the bit-serial divider (one
// quotient bit per cycle, 128 plus 0, 16 or 30 steps per division, up to ten
// divisions), a 4-pass 64-bit multiplier and a 32-step square root.
//
// Reset clears the count, all sums and any pending result, and sets
// min_variance to 1. A finished result waits in the output register while
// the receiver stalls; the next item is accepted meanwhile, and its result
// is held back until the previous one has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module paired_sample_regression_stats #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire psrs_pkg::t_in_item   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output psrs_pkg::t_out_item       o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [31:0]          i_cfg_data
);

    import psrs_pkg::*;

    localparam int SX_W = (SAMPLE_BITS + COUNT_BITS > 64) ? 64 : SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_W = (2 * SAMPLE_BITS + COUNT_BITS > 64) ? 64
                                                              : 2 * SAMPLE_BITS + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // Accumulator state.
    logic        [COUNT_BITS-1:0]  r_count, n_count;
    logic signed [SX_W-1:0]        r_sx, n_sx;
    logic signed [SX_W-1:0]        r_sy, n_sy;
    logic signed [SQ_W-1:0]        r_sxx, n_sxx;
    logic signed [SQ_W-1:0]        r_syy, n_syy;
    logic signed [SQ_W-1:0]        r_sxy, n_sxy;
    logic signed [SAMPLE_BITS-1:0] r_x, n_x;
    logic signed [SAMPLE_BITS-1:0] r_y, n_y;
    logic        [31:0]            r_min_var;

    // Sequencer and intermediate values.
    t_seq_state          r_state, n_state;
    logic                r_issued, n_issued;
    logic [63:0]         r_t1, n_t1;
    logic [63:0]         r_dx, n_dx;
    logic [63:0]         r_dy, n_dy;
    logic [63:0]         r_c, n_c;
    logic [63:0]         r_n2, n_n2;
    logic [63:0]         r_den, n_den;
    logic [31:0]         r_rx, n_rx;
    logic [31:0]         r_ry, n_ry;
    logic [127:0]        r_w, n_w;
    logic signed [31:0]  r_mx, n_mx;
    logic signed [31:0]  r_my, n_my;
    logic [47:0]         r_mse, n_mse;
    logic [47:0]         r_cse, n_cse;
    logic signed [31:0]  r_corr, n_corr;
    logic signed [47:0]  r_slope, n_slope;
    logic signed [47:0]  r_icpt, n_icpt;
    logic [47:0]         r_resid, n_resid;
    logic                r_degen, n_degen;
    t_out_item           r_out, n_out;
    logic                r_out_valid, n_out_valid;

    // Shared unit connections.
    logic         use_mul, use_div, use_sqrt;
    logic         mul_done, div_done, sqrt_done;
    logic [63:0]  mul_a, mul_b;
    logic [127:0] mul_prod;
    logic [127:0] div_num;
    logic [4:0]   div_sh;
    logic [63:0]  div_den;
    logic [127:0] div_quo;
    logic [63:0]  sqrt_val;
    logic [31:0]  sqrt_root;

    logic [63:0] n64, sx64, sy64, sxx64, syy64, sxy64, x64, y64, in_x64, in_y64;

    assign n64    = 64'(r_count);
    assign sx64   = 64'(r_sx);
    assign sy64   = 64'(r_sy);
    assign sxx64  = 64'(r_sxx);
    assign syy64  = 64'(r_syy);
    assign sxy64  = 64'(r_sxy);
    assign x64    = 64'(r_x);
    assign y64    = 64'(r_y);
    assign in_x64 = 64'(i_in_data.x_sample);
    assign in_y64 = 64'(i_in_data.y_sample);

    psrs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (use_mul && !r_issued),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    psrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (use_div && !r_issued),
        .i_num   (div_num),
        .i_sh    (div_sh),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    psrs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (use_sqrt && !r_issued),
        .i_val   (sqrt_val),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_var <= 32'd1;
        end else if (i_cfg_valid) begin
            r_min_var <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_sxx       <= '0;
            r_syy       <= '0;
            r_sxy       <= '0;
        end else begin
            r_state     <= n_state;
            r_issued    <= n_issued;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_sx        <= n_sx;
            r_sy        <= n_sy;
            r_sxx       <= n_sxx;
            r_syy       <= n_syy;
            r_sxy       <= n_sxy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_y     <= n_y;
        r_t1    <= n_t1;
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_c     <= n_c;
        r_n2    <= n_n2;
        r_den   <= n_den;
        r_rx    <= n_rx;
        r_ry    <= n_ry;
        r_w     <= n_w;
        r_mx    <= n_mx;
        r_my    <= n_my;
        r_mse   <= n_mse;
        r_cse   <= n_cse;
        r_corr  <= n_corr;
        r_slope <= n_slope;
        r_icpt  <= n_icpt;
        r_resid <= n_resid;
        r_degen <= n_degen;
        r_out   <= n_out;
    end

    always_comb begin
        logic         done;
        logic [63:0]  sres;
        logic [127:0] wprod;
        logic [127:0] wmag;

        n_state     = r_state;
        n_issued    = r_issued;
        n_count     = r_count;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_sxx       = r_sxx;
        n_syy       = r_syy;
        n_sxy       = r_sxy;
        n_x         = r_x;
        n_y         = r_y;
        n_t1        = r_t1;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_c         = r_c;
        n_n2        = r_n2;
        n_den       = r_den;
        n_rx        = r_rx;
        n_ry        = r_ry;
        n_w         = r_w;
        n_mx        = r_mx;
        n_my        = r_my;
        n_mse       = r_mse;
        n_cse       = r_cse;
        n_corr      = r_corr;
        n_slope     = r_slope;
        n_icpt      = r_icpt;
        n_resid     = r_resid;
        n_degen     = r_degen;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        use_mul  = 1'b0;
        use_div  = 1'b0;
        use_sqrt = 1'b0;
        mul_a    = 64'd0;
        mul_b    = 64'd0;
        div_num  = 128'd0;
        div_sh   = SH_INT;
        div_den  = 64'd0;
        sqrt_val = 64'd0;
        sres     = 64'd0;
        wprod    = 128'd0;
        wmag     = 128'd0;

        // Operand selection for the unit that the current step uses.
        unique case (r_state)
            S_XX: begin
                use_mul = 1'b1; mul_a = x64; mul_b = x64;
            end
            S_YY: begin
                use_mul = 1'b1; mul_a = y64; mul_b = y64;
            end
            S_XY: begin
                use_mul = 1'b1; mul_a = x64; mul_b = y64;
            end
            S_NSXX: begin
                use_mul = 1'b1; mul_a = n64; mul_b = sxx64;
            end
            S_SXSX: begin
                use_mul = 1'b1; mul_a = sx64; mul_b = sx64;
            end
            S_NSYY: begin
                use_mul = 1'b1; mul_a = n64; mul_b = syy64;
            end
            S_SYSY: begin
                use_mul = 1'b1; mul_a = sy64; mul_b = sy64;
            end
            S_NSXY: begin
                use_mul = 1'b1; mul_a = n64; mul_b = sxy64;
            end
            S_SXSY: begin
                use_mul = 1'b1; mul_a = sx64; mul_b = sy64;
            end
            S_NN: begin
                use_mul = 1'b1; mul_a = n64; mul_b = n64;
            end
            S_MX: begin
                use_div = 1'b1; div_num = {64'd0, f_mag(sx64)};
                div_sh = SH_Q16; div_den = n64;
            end
            S_MY: begin
                use_div = 1'b1; div_num = {64'd0, f_mag(sy64)};
                div_sh = SH_Q16; div_den = n64;
            end
            S_MSE: begin
                use_div = 1'b1;
                div_num = {64'd0, f_clamp0(sxx64 - (sxy64 << 1) + syy64)};
                div_sh = SH_Q16; div_den = n64;
            end
            S_CSE: begin
                use_div = 1'b1;
                div_num = {64'd0, f_clamp0(r_dx + r_dy - (r_c << 1))};
                div_sh = SH_Q16; div_den = r_n2;
            end
            S_RTX: begin
                use_sqrt = 1'b1; sqrt_val = r_dx;
            end
            S_RTY: begin
                use_sqrt = 1'b1; sqrt_val = r_dy;
            end
            S_DEN: begin
                use_mul = 1'b1; mul_a = 64'(r_rx); mul_b = 64'(r_ry);
            end
            S_COR: begin
                use_div = 1'b1; div_num = {64'd0, f_mag(r_c)};
                div_sh = SH_Q30; div_den = r_den;
            end
            S_VARX: begin
                use_div = 1'b1; div_num = {64'd0, r_dx};
                div_sh = SH_Q16; div_den = r_n2;
            end
            S_RESD: begin
                use_div = 1'b1; div_num = {64'd0, r_dy};
                div_sh = SH_Q16; div_den = r_n2;
            end
            S_SLOPE: begin
                use_div = 1'b1; div_num = {64'd0, f_mag(r_c)};
                div_sh = SH_Q16; div_den = r_dx;
            end
            S_P1: begin
                use_mul = 1'b1; mul_a = f_mag(sxx64); mul_b = f_mag(sy64);
            end
            S_P2: begin
                use_mul = 1'b1; mul_a = f_mag(sxy64); mul_b = f_mag(sx64);
            end
            S_ICPT: begin
                use_div = 1'b1;
                div_num = r_w[127] ? (128'd0 - r_w) : r_w;
                div_sh = SH_Q16; div_den = r_dx;
            end
            S_PQ1: begin
                use_mul = 1'b1; mul_a = r_dx; mul_b = r_dy;
            end
            S_PQ2: begin
                use_mul = 1'b1; mul_a = f_mag(r_c); mul_b = f_mag(r_c);
            end
            S_RES1: begin
                use_div = 1'b1; div_num = r_w; div_sh = SH_Q16; div_den = r_dx;
            end
            S_RES2: begin
                use_div = 1'b1; div_num = r_w; div_sh = SH_INT; div_den = r_n2;
            end
            default: begin
            end
        endcase

        done = (use_mul && mul_done) || (use_div && div_done) || (use_sqrt && sqrt_done);
        if ((use_mul || use_div || use_sqrt) && !r_issued) begin
            n_issued = 1'b1;
        end
        if (done) begin
            n_issued = 1'b0;
        end

        // Result capture and step order.
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_x = i_in_data.x_sample;
                    n_y = i_in_data.y_sample;
                    if (i_in_data.action == ACT_CLEAR) begin
                        n_count = '0;
                        n_sx    = '0;
                        n_sy    = '0;
                        n_sxx   = '0;
                        n_syy   = '0;
                        n_sxy   = '0;
                        n_state = S_CHK;
                    end else if (r_count != CNT_MAX) begin
                        n_count = r_count + 1'b1;
                        n_sx    = SX_W'(sx64 + in_x64);
                        n_sy    = SX_W'(sy64 + in_y64);
                        n_state = S_XX;
                    end else begin
                        // A full count ignores the pair but still reports.
                        n_state = S_CHK;
                    end
                end
            end
            S_XX: if (done) begin
                n_sxx = SQ_W'(sxx64 + mul_prod[63:0]); n_state = S_YY;
            end
            S_YY: if (done) begin
                n_syy = SQ_W'(syy64 + mul_prod[63:0]); n_state = S_XY;
            end
            S_XY: if (done) begin
                n_sxy = SQ_W'(sxy64 + mul_prod[63:0]); n_state = S_CHK;
            end
            S_CHK: begin
                n_state = (n64 == 64'd0) ? S_OUT : S_NSXX;
            end
            S_NSXX: if (done) begin
                n_t1 = mul_prod[63:0]; n_state = S_SXSX;
            end
            S_SXSX: if (done) begin
                n_dx = f_clamp0(r_t1 - mul_prod[63:0]); n_state = S_NSYY;
            end
            S_NSYY: if (done) begin
                n_t1 = mul_prod[63:0]; n_state = S_SYSY;
            end
            S_SYSY: if (done) begin
                n_dy = f_clamp0(r_t1 - mul_prod[63:0]); n_state = S_NSXY;
            end
            S_NSXY: if (done) begin
                n_t1 = mul_prod[63:0]; n_state = S_SXSY;
            end
            S_SXSY: if (done) begin
                n_c = r_t1 - mul_prod[63:0]; n_state = S_NN;
            end
            S_NN: if (done) begin
                n_n2 = mul_prod[63:0]; n_state = S_MX;
            end
            S_MX: if (done) begin
                sres = f_ssat(div_quo, LIM_MEAN, sx64[63]);
                n_mx = sres[31:0]; n_state = S_MY;
            end
            S_MY: if (done) begin
                sres = f_ssat(div_quo, LIM_MEAN, sy64[63]);
                n_my = sres[31:0]; n_state = S_MSE;
            end
            S_MSE: if (done) begin
                sres  = f_usat(div_quo, MAX_UQ48);
                n_mse = sres[47:0]; n_state = S_CSE;
            end
            S_CSE: if (done) begin
                sres  = f_usat(div_quo, MAX_UQ48);
                n_cse = sres[47:0]; n_state = S_RTX;
            end
            S_RTX: if (done) begin
                n_rx = sqrt_root; n_state = S_RTY;
            end
            S_RTY: if (done) begin
                n_ry = sqrt_root; n_state = S_DEN;
            end
            S_DEN: if (done) begin
                n_den = mul_prod[63:0];
                if (mul_prod[63:0] == 64'd0) begin
                    n_corr  = '0;
                    n_state = S_VARX;
                end else begin
                    n_state = S_COR;
                end
            end
            S_COR: if (done) begin
                sres   = f_ssat(div_quo, LIM_CORR, r_c[63]);
                n_corr = sres[31:0]; n_state = S_VARX;
            end
            S_VARX: if (done) begin
                sres = f_usat(div_quo, MAX_UQ48);
                if (sres <= 64'(r_min_var)) begin
                    n_degen = 1'b1;
                    n_slope = '0;
                    n_icpt  = 48'(r_my);
                    n_state = S_RESD;
                end else begin
                    n_degen = 1'b0;
                    n_state = S_SLOPE;
                end
            end
            S_RESD: if (done) begin
                sres    = f_usat(div_quo, MAX_UQ48);
                n_resid = sres[47:0]; n_state = S_OUT;
            end
            S_SLOPE: if (done) begin
                sres    = f_ssat(div_quo, LIM_FIT, r_c[63]);
                n_slope = sres[47:0]; n_state = S_P1;
            end
            S_P1: if (done) begin
                n_w = (sxx64[63] ^ sy64[63]) ? (128'd0 - mul_prod) : mul_prod;
                n_state = S_P2;
            end
            S_P2: if (done) begin
                wprod = (sxy64[63] ^ sx64[63]) ? (128'd0 - mul_prod) : mul_prod;
                n_w = r_w - wprod; n_state = S_ICPT;
            end
            S_ICPT: if (done) begin
                sres   = f_ssat(div_quo, LIM_FIT, r_w[127]);
                n_icpt = sres[47:0]; n_state = S_PQ1;
            end
            S_PQ1: if (done) begin
                n_w = mul_prod; n_state = S_PQ2;
            end
            S_PQ2: if (done) begin
                // When C^2 exceeds Dx*Dy the residual is negative and clamps.
                if (mul_prod > r_w) begin
                    n_resid = '0;
                    n_state = S_OUT;
                end else begin
                    wmag    = r_w - mul_prod;
                    n_w     = wmag;
                    n_state = S_RES1;
                end
            end
            S_RES1: if (done) begin
                n_w = div_quo; n_state = S_RES2;
            end
            S_RES2: if (done) begin
                sres    = f_usat(div_quo, MAX_UQ48);
                n_resid = sres[47:0]; n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (n64 == 64'd0) begin
                        n_out            = '0;
                        n_out.no_samples = 1'b1;
                    end else begin
                        n_out.sample_count      = n64[15:0];
                        n_out.mean_x            = r_mx;
                        n_out.mean_y            = r_my;
                        n_out.mean_sq_error     = r_mse;
                        n_out.centered_sq_error = r_cse;
                        n_out.correlation       = r_corr;
                        n_out.slope             = r_slope;
                        n_out.intercept         = r_icpt;
                        n_out.residual_variance = r_resid;
                        n_out.fit_degenerate    = r_degen;
                        n_out.no_samples        = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // An accepted item keeps the input side closed on the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted twice in a row");

    // Only one shared unit is started at a time.
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({use_mul, use_div, use_sqrt}))
        else $error("more than one arithmetic unit selected");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.no_samples) |->
            (o_out_data.sample_count == 16'd0 && o_out_data.slope == 48'sd0
             && o_out_data.fit_degenerate == 1'b0))
        else $error("empty result carries data");

    a_degenerate_slope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.fit_degenerate) |-> (o_out_data.slope == 48'sd0))
        else $error("degenerate fit with nonzero slope");

    a_corr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.correlation <= 32'sh4000_0000
                         && o_out_data.correlation >= -32'sh4000_0000))
        else $error("correlation out of range");

endmodule

`default_nettype wire

/* tb/paired_sample_regression_stats_tb.sv */
// ----------------------------------------------------------------------------
// paired_sample_regression_stats_tb
// Self-checking bench for the running regression statistics block. Pairs and
// clears are sent in random bursts. Each result is compared field by field
// with an in-bench predictor that works in wide integer arithmetic. The
// min_variance register is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import psrs_pkg::*;

class regression_scoreboard;
    logic [63:0] cnt, sx, sy, sxx, syy, sxy;
    logic [63:0] min_var;
    t_out_item   pending_q[$];
    int          errors;
    int          checked;
    int          degenerate_seen;

    function new();
        cnt = 0; sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
        min_var = 1;
        errors = 0; checked = 0; degenerate_seen = 0;
    endfunction

    function void set_min_variance(logic [31:0] v);
        min_var = {32'd0, v};
    endfunction

    // floor(num * 2^sh / den); all ones when the quotient needs more than 128 bits.
    function logic [127:0] quot(logic [127:0] num, int sh, logic [63:0] den);
        logic [191:0] w;
        if (den == 0) return 128'd0;
        w = {64'd0, num} << sh;
        w = w / {128'd0, den};
        if (w[191:128] != 0) return {128{1'b1}};
        return w[127:0];
    endfunction

    function logic [63:0] limit(logic [127:0] q, logic [63:0] lim);
        return (q[127:64] != 0 || q[63:0] > lim) ? lim : q[63:0];
    endfunction

    function logic [63:0] uq(logic [63:0] num, int sh, logic [63:0] den);
        return limit(quot({64'd0, num}, sh, den), 64'h0000_FFFF_FFFF_FFFF);
    endfunction

    function logic [63:0] sq(logic [63:0] v, int sh, logic [63:0] den, int lb);
        logic        neg;
        logic [63:0] m, lim, r;
        neg = v[63];
        m = neg ? -v : v;
        lim = 64'd1 << lb;
        r = limit(quot({64'd0, m}, sh, den), neg ? lim : lim - 1);
        return neg ? -r : r;
    endfunction

    function logic [63:0] root(logic [63:0] v);
        logic [63:0]  r;
        logic [127:0] t;
        int           b;
        r = 0;
        for (b = 31; b >= 0; b--) begin
            t = {64'd0, r | (64'd1 << b)};
            if (t * t <= {64'd0, v}) r = r | (64'd1 << b);
        end
        return r;
    endfunction

    function logic [63:0] nonneg(logic [63:0] v);
        return v[63] ? 64'd0 : v;
    endfunction

    // Updates the sums for one accepted transfer and queues the expected result.
    function void note_item(t_in_item it);
        logic [63:0]  x, y, n, n2, dx, dy, c, varx, den, m, p_hi;
        logic [127:0] num, p, q, t;
        logic         neg;
        t_out_item    r;
        r = '0;
        if (it.action == ACT_CLEAR) begin
            cnt = 0; sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
        end else if (cnt < 64'd65535) begin
            x = {{48{it.x_sample[15]}}, it.x_sample};
            y = {{48{it.y_sample[15]}}, it.y_sample};
            cnt = cnt + 1;
            sx = sx + x; sy = sy + y;
            sxx = sxx + x * x; syy = syy + y * y; sxy = sxy + x * y;
        end
        n = cnt;
        if (n == 0) begin
            r.no_samples = 1'b1;
            pending_q.push_back(r);
            return;
        end
        n2 = n * n;
        dx = nonneg(n * sxx - sx * sx);
        dy = nonneg(n * syy - sy * sy);
        c = n * sxy - sx * sy;
        r.sample_count = n[15:0];
        r.mean_x = 32'(sq(sx, 16, n, 31));
        r.mean_y = 32'(sq(sy, 16, n, 31));
        r.mean_sq_error = 48'(uq(nonneg(sxx - 2 * sxy + syy), 16, n));
        r.centered_sq_error = 48'(uq(nonneg(dx + dy - 2 * c), 16, n2));
        den = root(dx) * root(dy);
        r.correlation = (den == 0) ? 32'd0 : 32'(sq(c, 30, den, 30));
        varx = uq(dx, 16, n2);
        if (varx <= min_var) begin
            r.fit_degenerate = 1'b1;
            r.slope = '0;
            r.intercept = 48'(sq(sy, 16, n, 31));
            r.residual_variance = 48'(uq(dy, 16, n2));
        end else begin
            r.slope = 48'(sq(c, 16, dx, 47));
            num = {{64{sxx[63]}}, sxx} * {{64{sy[63]}}, sy}
                - {{64{sxy[63]}}, sxy} * {{64{sx[63]}}, sx};
            neg = num[127];
            if (neg) num = -num;
            m = limit(quot(num, 16, dx), neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF);
            r.intercept = 48'(neg ? -m : m);
            p = {64'd0, dx} * {64'd0, dy};
            p_hi = c[63] ? -c : c;
            q = {64'd0, p_hi} * {64'd0, p_hi};
            if (q > p) begin
                r.residual_variance = '0;
            end else begin
                t = quot(p - q, 16, dx);
                r.residual_variance = 48'(limit(quot(t, 0, n2), 64'h0000_FFFF_FFFF_FFFF));
            end
        end
        pending_q.push_back(r);
    endfunction

    function void field(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
        end
    endfunction

    function void check_result(t_out_item a);
        t_out_item e;
        if (pending_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $time, a);
            return;
        end
        e = pending_q.pop_front();
        checked++;
        if (e.fit_degenerate) degenerate_seen++;
        field("sample_count", 64'(e.sample_count), 64'(a.sample_count));
        field("mean_x", 64'(e.mean_x), 64'(a.mean_x));
        field("mean_y", 64'(e.mean_y), 64'(a.mean_y));
        field("mean_sq_error", 64'(e.mean_sq_error), 64'(a.mean_sq_error));
        field("centered_sq_error", 64'(e.centered_sq_error), 64'(a.centered_sq_error));
        field("correlation", 64'(e.correlation), 64'(a.correlation));
        field("slope", 64'(e.slope), 64'(a.slope));
        field("intercept", 64'(e.intercept), 64'(a.intercept));
        field("residual_variance", 64'(e.residual_variance), 64'(a.residual_variance));
        field("fit_degenerate", 64'(e.fit_degenerate), 64'(a.fit_degenerate));
        field("no_samples", 64'(e.no_samples), 64'(a.no_samples));
    endfunction
endclass

module paired_sample_regression_stats_tb;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_data = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        o_in_ready, o_out_valid, o_cfg_ready;
    t_out_item   o_out_data;

    regression_scoreboard stats_sb = new();
    int burst_left = 0;
    int items_sent = 0;
    int clears_sent = 0;
    int cfg_writes = 0;
    bit hold_done = 0;

    paired_sample_regression_stats dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #(100ms);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_item(input logic act, input logic [15:0] x, input logic [15:0] y);
        t_in_item it;
        it.action = act;
        it.x_sample = x;
        it.y_sample = y;
        if (burst_left == 0) begin
            // A burst always ends with valid low before the next one starts.
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 300) : $urandom_range(1, 6))
                @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        stats_sb.note_item(it);
        items_sent++;
        if (act == ACT_CLEAR) clears_sent++;
        burst_left--;
        if (burst_left == 0) in_valid <= 1'b0;
    endtask

    task automatic write_min_variance(input logic [31:0] v);
        if (burst_left != 0) in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (stats_sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        stats_sb.set_min_variance(v);
        cfg_writes++;
    endtask

    function automatic logic [15:0] clip16(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    // One clear followed by a short set of pairs of a randomly chosen shape.
    task automatic send_random_set();
        int kind, len, span, k, b, xv, yv, i;
        logic [15:0] fixed_x, fixed_y;
        kind = $urandom_range(0, 6);
        len = $urandom_range(1, 12);
        span = 1 << $urandom_range(1, 15);
        k = $urandom_range(0, 8) - 4;
        b = $urandom_range(0, 2000) - 1000;
        fixed_x = 16'($urandom);
        fixed_y = 16'($urandom);
        send_item(ACT_CLEAR, 16'($urandom), 16'($urandom));
        for (i = 0; i < len; i++) begin
            xv = $urandom_range(0, 2 * span - 1) - span;
            yv = $urandom_range(0, 2 * span - 1) - span;
            case (kind)
                0: send_item(ACT_ADD, 16'($urandom), 16'($urandom));
                1: send_item(ACT_ADD, clip16(xv), clip16(yv));
                2: send_item(ACT_ADD, fixed_x, clip16(yv));
                3: send_item(ACT_ADD, clip16(xv),
                             clip16(k * xv + b + $urandom_range(0, 2) - 1));
                4: send_item(ACT_ADD, clip16(xv), fixed_y);
                5: send_item(ACT_ADD, $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF,
                             $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF);
                default: begin
                    // Noise: a stray clear now and then inside the set.
                    if ($urandom_range(0, 3) == 0)
                        send_item(ACT_CLEAR, 16'($urandom), 16'($urandom));
                    else send_item(ACT_ADD, clip16(xv), 16'($urandom));
                end
            endcase
        end
    endtask

    // Receiver: stall pattern switches mode every stretch, plus one long hold-off.
    initial begin
        int mode, stretch, hold;
        mode = 0;
        stretch = 0;
        forever begin
            if (!hold_done && stats_sb.checked >= 300) begin
                hold_done = 1;
                out_ready <= 1'b0;
                for (hold = 0; hold < 8000; hold++) @(posedge i_clk);
            end
            if (stretch == 0) begin
                mode = $urandom_range(0, 3);
                stretch = $urandom_range(50, 3000);
            end
            stretch--;
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 1);
                2: out_ready <= ($urandom_range(0, 7) == 0);
                default: out_ready <= (stretch % 5 != 0);
            endcase
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && out_ready) stats_sb.check_result(o_out_data);
        end
    end

    initial begin
        int wait_cycles;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with no degenerate threshold.
        write_min_variance(32'd0);
        send_item(ACT_ADD, 16'd0, 16'd0);
        send_item(ACT_ADD, 16'h7FFF, 16'h7FFF);
        send_item(ACT_ADD, 16'h8000, 16'h8000);
        send_item(ACT_ADD, 16'h8000, 16'h7FFF);
        send_item(ACT_ADD, 16'h7FFF, 16'h8000);
        send_item(ACT_CLEAR, 16'hFFFF, 16'hFFFF);
        send_item(ACT_ADD, 16'd5, 16'd7);
        send_item(ACT_ADD, 16'd5, -16'sd3);
        send_item(ACT_ADD, 16'd5, 16'd100);
        send_item(ACT_CLEAR, 16'h0000, 16'h0000);
        send_item(ACT_ADD, 16'd1, 16'd3);
        send_item(ACT_ADD, 16'd2, 16'd5);
        send_item(ACT_ADD, 16'd3, 16'd7);
        send_item(ACT_ADD, 16'd4, 16'd0);
        send_item(ACT_CLEAR, 16'h8000, 16'h7FFF);
        send_item(ACT_ADD, -16'sd100, 16'd9);
        send_item(ACT_ADD, 16'd200, 16'd9);
        send_item(ACT_ADD, 16'd300, 16'd9);
        send_item(ACT_CLEAR, 16'h7FFF, 16'h8000);
        send_item(ACT_ADD, 16'h7FFF, 16'h8000);
        send_item(ACT_ADD, 16'h8000, 16'h7FFF);

        // Random phases over several thresholds, extremes included.
        write_min_variance(32'd1);
        while (items_sent < 400) send_random_set();
        write_min_variance(32'hFFFF_FFFF);
        while (items_sent < 750) send_random_set();
        write_min_variance($urandom);
        while (items_sent < 1100) send_random_set();
        write_min_variance($urandom_range(0, 32'h0010_0000));
        while (items_sent < 1500) send_random_set();

        if (burst_left != 0) in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        wait_cycles = 0;
        while (stats_sb.pending_q.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (2000) @(posedge i_clk);
        if (stats_sb.pending_q.size() != 0) begin
            stats_sb.errors++;
            $display("%0t: %0d results never arrived", $time, stats_sb.pending_q.size());
        end

        $display("Covered %0d transfers (%0d clears), %0d results checked, %0d degenerate fits.",
                 items_sent, clears_sent, stats_sb.checked, stats_sb.degenerate_seen);
        $display("The threshold register was written %0d times.", cfg_writes);
        if (stats_sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/psrs_pkg.sv
rtl/psrs_mul.sv
rtl/psrs_div.sv
rtl/psrs_sqrt.sv
rtl/paired_sample_regression_stats.sv
tb/paired_sample_regression_stats_tb.sv
